// ===== src/ides_pkg.sv =====
`timescale 1ns / 1ps

package ides_pkg;

   // one quotient or root bit per stage
   localparam int RecipSteps  = 33;
   localparam int MeanSteps   = 64;
   localparam int SqrtSteps   = 32;
   localparam int SpreadSteps = 48;
   localparam int Latency     = 185;

   // fields that ride along the whole pipe
   typedef struct packed {
      logic        dv;
      logic [15:0] support;
      logic [15:0] mask;
      logic [39:0] mean;
   } side_type;

endpackage

// ===== src/inverse_depth_evidence_stats.sv =====
`timescale 1ns / 1ps
// Each request passes through the bit-serial reciprocal, mean, square-root and
// spread dividers (one bit per stage) before its result appears on the rsp_
// ports.
// Throughput: one request per cycle; busy stays low.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
module inverse_depth_evidence_stats (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_depth,
   input  logic [15:0] req_vote_count,
   input  logic [15:0] req_source_mask,
   input  logic [39:0] req_inverse_sum,
   input  logic [63:0] req_inverse_square_sum,
   output logic        rsp_valid,
   output logic        rsp_depth_valid,
   output logic [15:0] rsp_support_count,
   output logic [15:0] rsp_mask_out,
   output logic [39:0] rsp_inverse_mean,
   output logic [31:0] rsp_relative_spread
);
   import ides_pkg::*;

   // reciprocal phase
   logic     a_vld_ff  [RecipSteps+1];
   side_type a_side_ff [RecipSteps+1];
   logic [31:0] a_den_ff [RecipSteps+1];
   logic [32:0] a_rem_ff [RecipSteps+1];
   logic [32:0] a_quo_ff [RecipSteps+1];
   logic [16:0] a_n_ff   [RecipSteps+1];
   logic [39:0] a_isum_ff [RecipSteps+1];
   logic [63:0] a_isq_ff  [RecipSteps+1];
   logic [32:0] a_rem_in [RecipSteps+1];
   logic [32:0] a_quo_in [RecipSteps+1];

   // square and sums
   logic        b_vld_ff;
   side_type    b_side_ff;
   logic [32:0] b_r_ff;
   logic [63:0] b_rsq_ff;
   logic [16:0] b_n_ff;
   logic [39:0] b_isum_ff;
   logic [63:0] b_isq_ff;
   logic        c_vld_ff;
   side_type    c_side_ff;
   logic [16:0] c_n_ff;
   logic [63:0] c_tsum_ff;
   logic [63:0] c_tsq_ff;
   logic [40:0] c_tsum_in;
   logic [64:0] c_tsq_in;

   // mean division, both sums by n
   logic     d_vld_ff  [MeanSteps+1];
   side_type d_side_ff [MeanSteps+1];
   logic [16:0] d_n_ff  [MeanSteps+1];
   logic [63:0] d_ns_ff [MeanSteps+1];
   logic [16:0] d_rs_ff [MeanSteps+1];
   logic [63:0] d_nq_ff [MeanSteps+1];
   logic [16:0] d_rq_ff [MeanSteps+1];
   logic [63:0] d_ns_in [MeanSteps+1];
   logic [16:0] d_rs_in [MeanSteps+1];
   logic [63:0] d_nq_in [MeanSteps+1];
   logic [16:0] d_rq_in [MeanSteps+1];

   // variance
   logic        e_vld_ff;
   side_type    e_side_ff;
   logic [63:0] e_msq_ff;
   logic [63:0] e_m2_ff;
   logic        e_big_ff;
   logic        f_vld_ff;
   side_type    f_side_ff;
   logic [63:0] f_var_ff;

   // square root
   logic     g_vld_ff  [SqrtSteps+1];
   side_type g_side_ff [SqrtSteps+1];
   logic [63:0] g_v_ff   [SqrtSteps+1];
   logic [63:0] g_res_ff [SqrtSteps+1];
   logic [63:0] g_v_in   [SqrtSteps+1];
   logic [63:0] g_res_in [SqrtSteps+1];

   // spread division
   logic     h_vld_ff  [SpreadSteps+1];
   side_type h_side_ff [SpreadSteps+1];
   logic [47:0] h_num_ff [SpreadSteps+1];
   logic [39:0] h_rem_ff [SpreadSteps+1];
   logic [47:0] h_num_in [SpreadSteps+1];
   logic [39:0] h_rem_in [SpreadSteps+1];

   logic [31:0] spread_in;

   assign busy = 1'b0;

   always_comb begin
      logic [32:0] trial_a;
      logic [17:0] trial_s;
      logic [17:0] trial_q;
      logic [64:0] test_g;
      logic [63:0] bit_g;
      logic [40:0] trial_h;
      // reciprocal: 2^32 / depth, dividend has a single one at the top
      for (int k = 0; k < RecipSteps; k++) begin
         trial_a = {a_rem_ff[k][31:0], k == 0};
         if (trial_a >= {1'b0, a_den_ff[k]}) begin
            a_rem_in[k+1] = trial_a - {1'b0, a_den_ff[k]};
            a_quo_in[k+1] = {a_quo_ff[k][31:0], 1'b1};
         end else begin
            a_rem_in[k+1] = trial_a;
            a_quo_in[k+1] = {a_quo_ff[k][31:0], 1'b0};
         end
      end
      a_rem_in[0] = '0;
      a_quo_in[0] = '0;

      c_tsum_in = {1'b0, b_isum_ff} + {8'd0, b_r_ff};
      c_tsq_in  = {1'b0, b_isq_ff} + {1'b0, b_rsq_ff};

      for (int k = 0; k < MeanSteps; k++) begin
         trial_s = {d_rs_ff[k], d_ns_ff[k][63]};
         if (trial_s >= {1'b0, d_n_ff[k]}) begin
            d_rs_in[k+1] = 17'(trial_s - {1'b0, d_n_ff[k]});
            d_ns_in[k+1] = {d_ns_ff[k][62:0], 1'b1};
         end else begin
            d_rs_in[k+1] = trial_s[16:0];
            d_ns_in[k+1] = {d_ns_ff[k][62:0], 1'b0};
         end
         trial_q = {d_rq_ff[k], d_nq_ff[k][63]};
         if (trial_q >= {1'b0, d_n_ff[k]}) begin
            d_rq_in[k+1] = 17'(trial_q - {1'b0, d_n_ff[k]});
            d_nq_in[k+1] = {d_nq_ff[k][62:0], 1'b1};
         end else begin
            d_rq_in[k+1] = trial_q[16:0];
            d_nq_in[k+1] = {d_nq_ff[k][62:0], 1'b0};
         end
      end
      d_rs_in[0] = '0;
      d_ns_in[0] = '0;
      d_rq_in[0] = '0;
      d_nq_in[0] = '0;

      for (int k = 0; k < SqrtSteps; k++) begin
         bit_g  = 64'd1 << (62 - 2 * k);
         test_g = {1'b0, g_res_ff[k]} + {1'b0, bit_g};
         if ({1'b0, g_v_ff[k]} >= test_g) begin
            g_v_in[k+1]   = 64'({1'b0, g_v_ff[k]} - test_g);
            g_res_in[k+1] = (g_res_ff[k] >> 1) + bit_g;
         end else begin
            g_v_in[k+1]   = g_v_ff[k];
            g_res_in[k+1] = g_res_ff[k] >> 1;
         end
      end
      g_v_in[0]   = '0;
      g_res_in[0] = '0;

      for (int k = 0; k < SpreadSteps; k++) begin
         trial_h = {h_rem_ff[k], h_num_ff[k][47]};
         if (trial_h >= {1'b0, h_side_ff[k].mean}) begin
            h_rem_in[k+1] = 40'(trial_h - {1'b0, h_side_ff[k].mean});
            h_num_in[k+1] = {h_num_ff[k][46:0], 1'b1};
         end else begin
            h_rem_in[k+1] = trial_h[39:0];
            h_num_in[k+1] = {h_num_ff[k][46:0], 1'b0};
         end
      end
      h_rem_in[0] = '0;
      h_num_in[0] = '0;

      if (h_side_ff[SpreadSteps].mean == '0) begin
         spread_in = '0;
      end else if (h_num_ff[SpreadSteps][47:32] != '0) begin
         spread_in = '1;
      end else begin
         spread_in = h_num_ff[SpreadSteps][31:0];
      end
   end

   always_ff @(posedge clock) begin
      logic [16:0] n_v;
      n_v = {1'b0, req_vote_count} + 17'd1;
      if (reset) begin
         for (int k = 0; k <= RecipSteps; k++) a_vld_ff[k] <= 1'b0;
         for (int k = 0; k <= MeanSteps; k++) d_vld_ff[k] <= 1'b0;
         for (int k = 0; k <= SqrtSteps; k++) g_vld_ff[k] <= 1'b0;
         for (int k = 0; k <= SpreadSteps; k++) h_vld_ff[k] <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         e_vld_ff  <= 1'b0;
         f_vld_ff  <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         a_vld_ff[0] <= start & ~busy;
         for (int k = 0; k < RecipSteps; k++) a_vld_ff[k+1] <= a_vld_ff[k];
         b_vld_ff    <= a_vld_ff[RecipSteps];
         c_vld_ff    <= b_vld_ff;
         d_vld_ff[0] <= c_vld_ff;
         for (int k = 0; k < MeanSteps; k++) d_vld_ff[k+1] <= d_vld_ff[k];
         e_vld_ff    <= d_vld_ff[MeanSteps];
         f_vld_ff    <= e_vld_ff;
         g_vld_ff[0] <= f_vld_ff;
         for (int k = 0; k < SqrtSteps; k++) g_vld_ff[k+1] <= g_vld_ff[k];
         h_vld_ff[0] <= g_vld_ff[SqrtSteps];
         for (int k = 0; k < SpreadSteps; k++) h_vld_ff[k+1] <= h_vld_ff[k];
         rsp_valid   <= h_vld_ff[SpreadSteps];
      end

      a_side_ff[0].dv      <= req_depth != '0;
      a_side_ff[0].support <= n_v[16] ? 16'hFFFF : n_v[15:0];
      a_side_ff[0].mask    <= req_source_mask;
      a_side_ff[0].mean    <= '0;
      a_den_ff[0]  <= req_depth;
      a_n_ff[0]    <= n_v;
      a_isum_ff[0] <= req_inverse_sum;
      a_isq_ff[0]  <= req_inverse_square_sum;
      a_rem_ff[0]  <= a_rem_in[0];
      a_quo_ff[0]  <= a_quo_in[0];
      for (int k = 0; k < RecipSteps; k++) begin
         a_side_ff[k+1] <= a_side_ff[k];
         a_den_ff[k+1]  <= a_den_ff[k];
         a_n_ff[k+1]    <= a_n_ff[k];
         a_isum_ff[k+1] <= a_isum_ff[k];
         a_isq_ff[k+1]  <= a_isq_ff[k];
         a_rem_ff[k+1]  <= a_rem_in[k+1];
         a_quo_ff[k+1]  <= a_quo_in[k+1];
      end

      b_side_ff <= a_side_ff[RecipSteps];
      b_r_ff    <= a_quo_ff[RecipSteps];
      b_rsq_ff  <= a_quo_ff[RecipSteps][32] ? '1 :
                   a_quo_ff[RecipSteps][31:0] * a_quo_ff[RecipSteps][31:0];
      b_n_ff    <= a_n_ff[RecipSteps];
      b_isum_ff <= a_isum_ff[RecipSteps];
      b_isq_ff  <= a_isq_ff[RecipSteps];

      c_side_ff <= b_side_ff;
      c_n_ff    <= b_n_ff;
      c_tsum_ff <= {24'd0, c_tsum_in[40] ? 40'hFF_FFFF_FFFF : c_tsum_in[39:0]};
      c_tsq_ff  <= c_tsq_in[64] ? '1 : c_tsq_in[63:0];

      d_side_ff[0] <= c_side_ff;
      d_n_ff[0]    <= c_n_ff;
      d_ns_ff[0]   <= c_tsum_ff;
      d_nq_ff[0]   <= c_tsq_ff;
      d_rs_ff[0]   <= d_rs_in[0];
      d_rq_ff[0]   <= d_rq_in[0];
      for (int k = 0; k < MeanSteps; k++) begin
         d_side_ff[k+1] <= d_side_ff[k];
         d_n_ff[k+1]    <= d_n_ff[k];
         d_ns_ff[k+1]   <= d_ns_in[k+1];
         d_rs_ff[k+1]   <= d_rs_in[k+1];
         d_nq_ff[k+1]   <= d_nq_in[k+1];
         d_rq_ff[k+1]   <= d_rq_in[k+1];
      end

      e_side_ff.dv      <= d_side_ff[MeanSteps].dv;
      e_side_ff.support <= d_side_ff[MeanSteps].support;
      e_side_ff.mask    <= d_side_ff[MeanSteps].mask;
      e_side_ff.mean    <= d_ns_ff[MeanSteps][39:0];
      e_msq_ff       <= d_nq_ff[MeanSteps];
      e_big_ff       <= d_ns_ff[MeanSteps][39:32] != '0;
      e_m2_ff        <= d_ns_ff[MeanSteps][31:0] * d_ns_ff[MeanSteps][31:0];

      f_side_ff <= e_side_ff;
      f_var_ff  <= (!e_big_ff && e_msq_ff > e_m2_ff) ? e_msq_ff - e_m2_ff : '0;

      g_side_ff[0] <= f_side_ff;
      g_v_ff[0]    <= f_var_ff;
      g_res_ff[0]  <= g_res_in[0];
      for (int k = 0; k < SqrtSteps; k++) begin
         g_side_ff[k+1] <= g_side_ff[k];
         g_v_ff[k+1]    <= g_v_in[k+1];
         g_res_ff[k+1]  <= g_res_in[k+1];
      end

      h_side_ff[0] <= g_side_ff[SqrtSteps];
      h_num_ff[0]  <= {g_res_ff[SqrtSteps][31:0], 16'd0};
      h_rem_ff[0]  <= h_rem_in[0];
      for (int k = 0; k < SpreadSteps; k++) begin
         h_side_ff[k+1] <= h_side_ff[k];
         h_num_ff[k+1]  <= h_num_in[k+1];
         h_rem_ff[k+1]  <= h_rem_in[k+1];
      end

      // no depth: every field reads zero
      rsp_depth_valid     <= h_side_ff[SpreadSteps].dv;
      rsp_support_count   <= h_side_ff[SpreadSteps].dv ? h_side_ff[SpreadSteps].support : '0;
      rsp_mask_out        <= h_side_ff[SpreadSteps].dv ? h_side_ff[SpreadSteps].mask : '0;
      rsp_inverse_mean    <= h_side_ff[SpreadSteps].dv ? h_side_ff[SpreadSteps].mean : '0;
      rsp_relative_spread <= h_side_ff[SpreadSteps].dv ? spread_in : '0;
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");
   a_no_stall: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_depth_valid |-> rsp_support_count == '0 && rsp_mask_out == '0
         && rsp_inverse_mean == '0 && rsp_relative_spread == '0)
      else $error("no-depth result not zero");
   a_valid_support: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_depth_valid |-> rsp_support_count != '0)
      else $error("zero support on valid depth");
   a_spread_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_relative_spread != '0 |-> rsp_inverse_mean != '0)
      else $error("spread without mean");

endmodule
